// ===== design/rc_pkg.sv =====
package rc_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MaxDigits  = 31;
  localparam int unsigned CodeWidth  = 8;
  localparam int unsigned CountWidth = $clog2(MaxDigits + 1);
  localparam int unsigned StepWidth  = $clog2(ValueWidth);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

  localparam logic [CodeWidth-1:0] AsciiZero = CodeWidth'(48);
  localparam logic [CodeWidth-1:0] MinBase   = CodeWidth'(2);

  localparam logic RegFromBase = 1'b0;
  localparam logic RegToBase   = 1'b1;

  typedef logic [ValueWidth-1:0] value_t;

  typedef struct packed {
    logic   valid;
    value_t value;
  } push_t;

  typedef struct packed {
    logic   full;
    logic   empty;
    value_t head;
  } queue_status_t;

endpackage

// ===== design/rc_queue.sv =====
module rc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rc_pkg::push_t          push_i,
  input  logic                   pop_i,
  output rc_pkg::queue_status_t  status_o
);

  rc_pkg::value_t                    mem_q [rc_pkg::QueueDepth];
  logic [rc_pkg::QPtrWidth-1:0]      wr_ptr_q, wr_ptr_d;
  logic [rc_pkg::QPtrWidth-1:0]      rd_ptr_q, rd_ptr_d;
  logic [rc_pkg::QCntWidth-1:0]      count_q, count_d;
  logic                              do_push;
  logic                              do_pop;

  assign status_o.full  = (count_q == rc_pkg::QCntWidth'(rc_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.head  = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rc_pkg::QPtrWidth'(rc_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rc_pkg::QPtrWidth'(rc_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.value;
    end
  end

endmodule

// ===== design/rc_front.sv =====
module rc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [rc_pkg::CodeWidth-1:0]  char_code_i,
  input  logic                          last_digit_i,
  input  logic [rc_pkg::CodeWidth-1:0]  from_base_i,
  output rc_pkg::push_t                 push_o
);

  rc_pkg::value_t                                   acc_q, acc_d;
  rc_pkg::value_t                                   product;
  rc_pkg::value_t                                   digit;
  rc_pkg::value_t                                   sum;

  assign product = acc_q * rc_pkg::value_t'(from_base_i);
  assign digit   = rc_pkg::ValueWidth'(char_code_i)
                 - rc_pkg::ValueWidth'(rc_pkg::AsciiZero);
  assign sum     = product + digit;

  assign push_o.valid = accept_i && last_digit_i;
  assign push_o.value = sum;

  always_comb begin
    acc_d = acc_q;
    if (accept_i) begin
      acc_d = last_digit_i ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== design/rc_back.sv =====
module rc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rc_pkg::queue_status_t         queue_i,
  output logic                          pop_o,
  input  logic [rc_pkg::CodeWidth-1:0]  to_base_i,
  output logic                          digit_strobe_o,
  output logic [rc_pkg::CodeWidth-1:0]  digit_code_o,
  output logic                          is_last_o,
  output logic                          is_empty_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]                          state_q, state_d;
  rc_pkg::value_t                      quot_q, quot_d;
  logic [rc_pkg::CodeWidth-1:0]        rem_q, rem_d;
  logic [rc_pkg::StepWidth-1:0]        step_q, step_d;
  logic [rc_pkg::CountWidth-1:0]       count_q, count_d;
  logic [rc_pkg::CodeWidth-1:0]        store_q [rc_pkg::MaxDigits];
  logic                                store_we;
  logic                                strobe_q, strobe_d;
  logic [rc_pkg::CodeWidth-1:0]        code_q, code_d;
  logic                                last_q, last_d;
  logic                                empty_q, empty_d;
  logic [rc_pkg::CodeWidth-1:0]        base;
  logic [rc_pkg::CodeWidth:0]          trial;
  logic                                fits;
  logic [rc_pkg::CodeWidth-1:0]        rem_step;
  rc_pkg::value_t                      quot_step;
  logic [rc_pkg::CountWidth-1:0]       count_dec;

  assign base      = (to_base_i < rc_pkg::MinBase) ? rc_pkg::MinBase : to_base_i;
  assign trial     = {rem_q, quot_q[rc_pkg::ValueWidth-1]};
  assign fits      = (trial >= {1'b0, base});
  assign rem_step  = fits ? rc_pkg::CodeWidth'(trial - {1'b0, base})
                          : trial[rc_pkg::CodeWidth-1:0];
  assign quot_step = {quot_q[rc_pkg::ValueWidth-2:0], fits};
  assign count_dec = count_q - 1'b1;

  always_comb begin
    state_d  = state_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    step_d   = step_q;
    count_d  = count_q;
    store_we = 1'b0;
    pop_o    = 1'b0;
    strobe_d = 1'b0;
    code_d   = code_q;
    last_d   = last_q;
    empty_d  = empty_q;
    case (state_q)
      StIdle: begin
        if (!queue_i.empty) begin
          pop_o = 1'b1;
          if (queue_i.head == '0 || queue_i.head[rc_pkg::ValueWidth-1]) begin
            strobe_d = 1'b1;
            code_d   = '0;
            last_d   = 1'b1;
            empty_d  = 1'b1;
          end else begin
            quot_d  = queue_i.head;
            rem_d   = '0;
            step_d  = '0;
            count_d = '0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        quot_d = quot_step;
        rem_d  = rem_step;
        step_d = step_q + 1'b1;
        if (step_q == rc_pkg::StepWidth'(rc_pkg::ValueWidth - 1)) begin
          store_we = 1'b1;
          count_d  = count_q + 1'b1;
          rem_d    = '0;
          step_d   = '0;
          if (quot_step == '0
              || count_q == rc_pkg::CountWidth'(rc_pkg::MaxDigits - 1)) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        strobe_d = 1'b1;
        code_d   = store_q[count_dec] + rc_pkg::AsciiZero;
        last_d   = (count_q == rc_pkg::CountWidth'(1));
        empty_d  = 1'b0;
        count_d  = count_dec;
        if (count_q == rc_pkg::CountWidth'(1)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      step_q   <= '0;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    code_q  <= code_d;
    last_q  <= last_d;
    empty_q <= empty_d;
    if (store_we) begin
      store_q[count_q] <= rem_step;
    end
  end

  assign digit_strobe_o = strobe_q;
  assign digit_code_o   = code_q;
  assign is_last_o      = last_q;
  assign is_empty_o     = empty_q;

endmodule

// ===== design/radix_converter.sv =====
// Radix converter: takes a number one character code per word, most
// significant digit first, and gives it back as character codes in another
// radix, most significant digit first.
// Input: a word is taken at a rising edge with start high and busy low.
// Each digit word is folded into the accumulator as it is taken, so digits
// may arrive back to back. The word with last_digit_i high closes the
// number and hands its value to a two-entry queue.
// Conversion: the back end pops a value and divides it by to_base with a
// restoring divider, one quotient bit per cycle; to_base below 2 acts as 2.
// When all output digits of a number are computed, its result words follow,
// one result word per cycle.
// A value of zero or less gives a single word with is_empty_o high.
// busy rises only while the queue holds two numbers not yet converted.
// Output: each result word stands for one cycle, marked by digit_strobe_o;
// the receiver cannot stall it. Configuration: cfg_we_i writes cfg_data_i
// to register cfg_idx_i (0 from_base, 1 to_base); the user must do so only
// while the block is idle; the block does not enforce it. Both reset to 10.
// Reset clears the accumulator, the queue and the converter state.
module radix_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rc_pkg::CodeWidth-1:0]  cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [rc_pkg::CodeWidth-1:0]  char_code_i,
  input  logic                          last_digit_i,
  output logic                          digit_strobe_o,
  output logic [rc_pkg::CodeWidth-1:0]  digit_code_o,
  output logic                          is_last_o,
  output logic                          is_empty_o
);

  logic [rc_pkg::CodeWidth-1:0]  from_base_q;
  logic [rc_pkg::CodeWidth-1:0]  to_base_q;
  logic                          accept;
  logic                          pop;
  rc_pkg::push_t                 push;
  rc_pkg::queue_status_t         queue_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_base_q <= rc_pkg::CodeWidth'(10);
      to_base_q   <= rc_pkg::CodeWidth'(10);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rc_pkg::RegFromBase) begin
        from_base_q <= cfg_data_i;
      end else begin
        to_base_q <= cfg_data_i;
      end
    end
  end

  assign busy   = queue_status.full;
  assign accept = start && !busy;

  rc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_code_i  (char_code_i),
    .last_digit_i (last_digit_i),
    .from_base_i  (from_base_q),
    .push_o       (push)
  );

  rc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (queue_status)
  );

  rc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_i        (queue_status),
    .pop_o          (pop),
    .to_base_i      (to_base_q),
    .digit_strobe_o (digit_strobe_o),
    .digit_code_o   (digit_code_o),
    .is_last_o      (is_last_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [rc_pkg::CodeWidth-1:0] code;
    logic                         last;
  } digit_in_t;

  typedef struct packed {
    logic [rc_pkg::CodeWidth-1:0] code;
    logic                         last;
    logic                         empty;
  } digit_word_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we = 1'b0;
  logic                         cfg_idx = rc_pkg::RegFromBase;
  logic [rc_pkg::CodeWidth-1:0] cfg_data = '0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [rc_pkg::CodeWidth-1:0] char_code = '0;
  logic                         last_digit = 1'b0;
  logic                         digit_strobe;
  logic [rc_pkg::CodeWidth-1:0] digit_code;
  logic                         is_last;
  logic                         is_empty;

  digit_in_t   pending_digits[$];
  digit_word_t expected_words[$];
  digit_in_t   next_digit;
  digit_word_t want_word;

  rc_pkg::value_t               acc_m = '0;
  logic [rc_pkg::CodeWidth-1:0] from_base_m = 8'd10;
  logic [rc_pkg::CodeWidth-1:0] to_base_m = 8'd10;
  int                           gap_pct = 8;
  int                           mismatch_count = 0;

  radix_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .start         (start),
    .busy          (busy),
    .char_code_i   (char_code),
    .last_digit_i  (last_digit),
    .digit_strobe_o(digit_strobe),
    .digit_code_o  (digit_code),
    .is_last_o     (is_last),
    .is_empty_o    (is_empty)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // fold one digit into the number; on the last digit queue the converted words
  task automatic fold_digit(input logic [rc_pkg::CodeWidth-1:0] code, input logic last);
    rc_pkg::value_t               val;
    rc_pkg::value_t               radix;
    logic [rc_pkg::CodeWidth-1:0] rems[$];
    acc_m = acc_m * rc_pkg::value_t'(from_base_m)
          + (rc_pkg::value_t'(code) - rc_pkg::value_t'(rc_pkg::AsciiZero));
    if (!last) return;
    val = acc_m;
    acc_m = '0;
    if (val == '0 || val[rc_pkg::ValueWidth-1]) begin
      expected_words.push_back('{'0, 1'b1, 1'b1});
      return;
    end
    radix = (to_base_m < rc_pkg::MinBase) ? rc_pkg::value_t'(rc_pkg::MinBase)
                                          : rc_pkg::value_t'(to_base_m);
    while (val != '0 && rems.size() < rc_pkg::MaxDigits) begin
      rems.push_front(rc_pkg::CodeWidth'(val % radix));
      val = val / radix;
    end
    foreach (rems[k])
      expected_words.push_back('{rems[k] + rc_pkg::AsciiZero, k == rems.size() - 1,
                                 1'b0});
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) fold_digit(char_code, last_digit);
      if (!start || !busy) begin
        if (pending_digits.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          next_digit = pending_digits.pop_front();
          start <= 1'b1;
          char_code <= next_digit.code;
          last_digit <= next_digit.last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && digit_strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: code %0d last %0b empty %0b", $time, digit_code,
                 is_last, is_empty);
        mismatch_count++;
      end else begin
        want_word = expected_words.pop_front();
        if (digit_code !== want_word.code) begin
          $display("%0t: digit_code expected %0d got %0d", $time, want_word.code, digit_code);
          mismatch_count++;
        end
        if (is_last !== want_word.last) begin
          $display("%0t: is_last expected %0b got %0b", $time, want_word.last, is_last);
          mismatch_count++;
        end
        if (is_empty !== want_word.empty) begin
          $display("%0t: is_empty expected %0b got %0b", $time, want_word.empty, is_empty);
          mismatch_count++;
        end
      end
    end
  end

  task automatic add_digit(input logic [rc_pkg::CodeWidth-1:0] code, input logic last);
    pending_digits.push_back('{code, last});
  endtask

  function automatic int add_random_number();
    int                           len;
    int                           hi;
    logic [rc_pkg::CodeWidth-1:0] code;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    hi = (from_base_m < 2) ? 9 : ((from_base_m > 208) ? 207 : from_base_m - 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) code = rc_pkg::CodeWidth'($urandom_range(0, 255));
      else code = rc_pkg::CodeWidth'(48 + $urandom_range(0, hi));
      pending_digits.push_back('{code, k == len - 1});
    end
    return len;
  endfunction

  task automatic wait_idle();
    while (pending_digits.size() != 0 || start || expected_words.size() != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [rc_pkg::CodeWidth-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == rc_pkg::RegFromBase) from_base_m = data;
    else to_base_m = data;
  endtask

  task automatic set_bases(input logic [rc_pkg::CodeWidth-1:0] src,
                           input logic [rc_pkg::CodeWidth-1:0] dst);
    wait_idle();
    write_reg(rc_pkg::RegFromBase, src);
    write_reg(rc_pkg::RegToBase, dst);
  endtask

  initial begin
    string                        num_text;
    int                           queued;
    logic [rc_pkg::CodeWidth-1:0] src;
    logic [rc_pkg::CodeWidth-1:0] dst;
    num_text = "2147483647";
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // zero, negative, top and bottom codes, a plain number
    add_digit(8'd48, 1'b1);
    add_digit(8'd47, 1'b1);
    add_digit(8'hFF, 1'b1);
    add_digit(8'h00, 1'b1);
    add_digit(8'd49, 1'b0);
    add_digit(8'd50, 1'b0);
    add_digit(8'd51, 1'b1);

    // largest positive value, full binary digit count
    set_bases(8'd10, 8'd2);
    for (int i = 0; i < num_text.len(); i++)
      add_digit(num_text[i], i == num_text.len() - 1);

    // zero source radix keeps only the newest digit
    set_bases(8'd0, 8'd255);
    add_digit(8'd57, 1'b0);
    add_digit(8'd53, 1'b1);
    add_digit(8'hFF, 1'b1);

    // wrap on overflow, target radix below two
    set_bases(8'd255, 8'd0);
    repeat (3) add_digit(8'hFF, 1'b0);
    add_digit(8'hFF, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      for (int blk = 0; blk < 3; blk++) begin
        src = ($urandom_range(0, 4) == 0) ? rc_pkg::CodeWidth'($urandom_range(0, 255))
                                          : rc_pkg::CodeWidth'($urandom_range(2, 36));
        dst = ($urandom_range(0, 1) == 0) ? rc_pkg::CodeWidth'($urandom_range(0, 255))
                                          : rc_pkg::CodeWidth'($urandom_range(2, 16));
        if (mode == 0 && blk == 0) dst = 8'd1;
        set_bases(src, dst);
        gap_pct = (mode == 0) ? 8 : ((mode == 1) ? 74 : 0);
        queued = 0;
        while (queued < 26) queued += add_random_number();
      end
    end

    wait_idle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("radix_converter: match");
    end else begin
      $display("radix_converter: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("radix_converter: mismatch");
    $finish;
  end

endmodule
